// ===== rtl/number_to_english_words_assert.svh =====
// Assertion macros shared by the number-to-words RTL.
`ifndef NUMBER_TO_ENGLISH_WORDS_ASSERT_SVH
`define NUMBER_TO_ENGLISH_WORDS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define N2EW_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define N2EW_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/n2ew_pkg.sv =====
// Widths, word codes and control structs for the number-to-words block.
package n2ew_pkg;

  localparam int VALUE_W = 40;
  localparam int WORD_W  = 6;
  localparam int SEP_W   = 2;
  localparam int NDIG    = 12;
  localparam int BCD_W   = NDIG * 4;
  localparam int CNT_W   = $clog2(VALUE_W + 1);

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 40'd999999999999;

  localparam logic [WORD_W-1:0] W_ZERO      = 6'd0;
  localparam logic [WORD_W-1:0] W_TEEN_BASE = 6'd10;
  localparam logic [WORD_W-1:0] W_TENS_BASE = 6'd18;
  localparam logic [WORD_W-1:0] W_HUNDRED   = 6'd28;
  localparam logic [WORD_W-1:0] W_ERROR     = 6'd32;

  localparam logic [SEP_W-1:0] SEP_NONE   = 2'd0;
  localparam logic [SEP_W-1:0] SEP_SPACE  = 2'd1;
  localparam logic [SEP_W-1:0] SEP_HYPHEN = 2'd2;

  // Converter status towards the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  // Start command towards the token emitter.
  typedef struct packed {
    logic start;
    logic err;
  } emit_cmd_t;

endpackage

// ===== rtl/n2ew_bcd.sv =====
// Binary to BCD converter, shift-and-add-3, one input bit per cycle.
module n2ew_bcd (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [n2ew_pkg::VALUE_W-1:0]   value,
  output logic [n2ew_pkg::BCD_W-1:0]     digits,
  output n2ew_pkg::conv_stat_t           stat
);

  logic [n2ew_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [n2ew_pkg::BCD_W-1:0]   bcd_r, bcd_nxt, adj;
  logic [n2ew_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < n2ew_pkg::NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = n2ew_pkg::CNT_W'(n2ew_pkg::VALUE_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[n2ew_pkg::BCD_W-2:0], bin_r[n2ew_pkg::VALUE_W-1]};
      bin_nxt = {bin_r[n2ew_pkg::VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == n2ew_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digits    = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`include "number_to_english_words_assert.svh"

  `N2EW_ASSERT_NOW(a_start_idle, start, !busy_r && !done_r, "converter restarted while busy")
  `N2EW_ASSERT_NEXT(a_done_once, done_r, !done_r, "converter done held longer than a cycle")
  `N2EW_ASSERT_NOW(a_busy_count, busy_r, cnt_r != '0, "converter busy with an empty count")

endmodule

// ===== rtl/n2ew_emit.sv =====
// Token sequencer: walks the digit groups and emits word tokens with a last flag.
module n2ew_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  n2ew_pkg::emit_cmd_t            cmd,
  input  logic [n2ew_pkg::BCD_W-1:0]     digits,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [n2ew_pkg::WORD_W-1:0]    out_word,
  output logic [n2ew_pkg::SEP_W-1:0]     out_separator,
  output logic                           out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  typedef enum logic [4:0] {
    PH_HUND  = 5'b00001,
    PH_HWRD  = 5'b00010,
    PH_REST  = 5'b00100,
    PH_ONES  = 5'b01000,
    PH_SCALE = 5'b10000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0] grp_r, grp_nxt;
  logic       first_r, first_nxt;
  logic       hold_valid_r, hold_valid_nxt;
  logic [n2ew_pkg::WORD_W-1:0] hold_word_r, hold_word_nxt;
  logic [n2ew_pkg::SEP_W-1:0]  hold_sep_r, hold_sep_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [n2ew_pkg::WORD_W-1:0] out_word_r, out_word_nxt;
  logic [n2ew_pkg::SEP_W-1:0]  out_sep_r, out_sep_nxt;
  logic       out_last_r, out_last_nxt;

  logic [11:0] grp_dig;
  logic [3:0]  dh, dt, dou;
  logic        group_zero, grp_end;
  logic        tok_en, tok_hyph;
  logic [n2ew_pkg::WORD_W-1:0] tok_word;
  logic        out_free, can_push;

  always_comb begin
    case (grp_r)
      2'd0:    grp_dig = digits[11:0];
      2'd1:    grp_dig = digits[23:12];
      2'd2:    grp_dig = digits[35:24];
      default: grp_dig = digits[47:36];
    endcase
  end

  assign dh = grp_dig[11:8];
  assign dt = grp_dig[7:4];
  assign dou = grp_dig[3:0];
  assign group_zero = (grp_dig == 12'd0);

  // Token that the current phase yields, if any
  always_comb begin
    tok_en   = 1'b0;
    tok_hyph = 1'b0;
    tok_word = n2ew_pkg::W_ZERO;
    unique case (phase_r)
      PH_HUND: begin
        tok_en   = (dh != 4'd0);
        tok_word = {2'b00, dh};
      end
      PH_HWRD: begin
        tok_en   = (dh != 4'd0);
        tok_word = n2ew_pkg::W_HUNDRED;
      end
      PH_REST: begin
        if (dt >= 4'd2) begin
          tok_en   = 1'b1;
          tok_word = n2ew_pkg::W_TENS_BASE + {2'b00, dt};
        end else if (dt == 4'd1) begin
          tok_en   = 1'b1;
          tok_word = n2ew_pkg::W_TEEN_BASE + {2'b00, dou};
        end else if (dou != 4'd0) begin
          tok_en   = 1'b1;
          tok_word = {2'b00, dou};
        end
      end
      PH_ONES: begin
        tok_en   = (dt >= 4'd2) && (dou != 4'd0);
        tok_hyph = 1'b1;
        tok_word = {2'b00, dou};
      end
      PH_SCALE: begin
        tok_en   = (grp_r != 2'd0);
        tok_word = n2ew_pkg::W_HUNDRED + {4'b0000, grp_r};
      end
      default: begin
        tok_en = 1'b0;
      end
    endcase
  end

  assign grp_end  = (phase_r == PH_SCALE) || ((phase_r == PH_HUND) && group_zero);
  assign out_free = !out_valid_r || !out_stall;
  assign can_push = !hold_valid_r || out_free;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    grp_nxt        = grp_r;
    first_nxt      = first_r;
    hold_valid_nxt = hold_valid_r;
    hold_word_nxt  = hold_word_r;
    hold_sep_nxt   = hold_sep_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_sep_nxt    = out_sep_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          if (cmd.err) begin
            hold_valid_nxt = 1'b1;
            hold_word_nxt  = n2ew_pkg::W_ERROR;
            hold_sep_nxt   = n2ew_pkg::SEP_NONE;
            state_nxt      = S_FLUSH;
          end else if (digits == '0) begin
            hold_valid_nxt = 1'b1;
            hold_word_nxt  = n2ew_pkg::W_ZERO;
            hold_sep_nxt   = n2ew_pkg::SEP_NONE;
            state_nxt      = S_FLUSH;
          end else begin
            grp_nxt   = 2'd3;
            phase_nxt = PH_HUND;
            first_nxt = 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        // Hold the phase while a token has nowhere to go
        if (!tok_en || can_push) begin
          if (tok_en) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = hold_word_r;
              out_sep_nxt   = hold_sep_r;
              out_last_nxt  = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_word_nxt  = tok_word;
            hold_sep_nxt   = first_r  ? n2ew_pkg::SEP_NONE :
                             tok_hyph ? n2ew_pkg::SEP_HYPHEN : n2ew_pkg::SEP_SPACE;
            first_nxt      = 1'b0;
          end
          if (grp_end) begin
            if (grp_r == 2'd0) begin
              state_nxt = S_FLUSH;
            end else begin
              grp_nxt   = grp_r - 2'd1;
              phase_nxt = PH_HUND;
            end
          end else begin
            unique case (phase_r)
              PH_HUND: phase_nxt = PH_HWRD;
              PH_HWRD: phase_nxt = PH_REST;
              PH_REST: phase_nxt = PH_ONES;
              default: phase_nxt = PH_SCALE;
            endcase
          end
        end
      end
      S_FLUSH: begin
        // The held token is the final one of this transaction
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = hold_word_r;
          out_sep_nxt    = hold_sep_r;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_HUND;
      grp_r        <= 2'd0;
      first_r      <= 1'b1;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      grp_r        <= grp_nxt;
      first_r      <= first_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_word_r <= hold_word_nxt;
    hold_sep_r  <= hold_sep_nxt;
    out_word_r  <= out_word_nxt;
    out_sep_r   <= out_sep_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_separator = out_sep_r;
  assign out_last_word = out_last_r;

`include "number_to_english_words_assert.svh"

  `N2EW_ASSERT_NOW(a_idle_empty, state_r == S_IDLE, !hold_valid_r, "token held while idle")
  `N2EW_ASSERT_NOW(a_flush_full, state_r == S_FLUSH, hold_valid_r, "flush without a held token")
  `N2EW_ASSERT_NOW(a_start_idle, cmd.start, state_r == S_IDLE, "emitter started while busy")

endmodule

// ===== rtl/number_to_english_words.sv =====
// Top level: spells a 40-bit number as a stream of English word tokens.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_value[39:0]
//  out_    | output    | out_valid / out_stall | out_word[5:0], out_separator[1:0],
//          |           |                       | out_last_word
//
// A legal value is shifted through the converter (one bit a cycle), then the sequencer walks
// one phase at a time (five per non-zero group, one per zero group) and flushes the last token.
// in_stall stays high until the sequencer is idle again. An out-of-range value skips the
// converter; its error token is loaded straight into the sequencer's hold register.
// rst_n is synchronous; it clears the converter and sequencer control state and out_valid.
// out_stall holds the sequencer only when a token must move into a full output stage.
module number_to_english_words (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [n2ew_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [n2ew_pkg::WORD_W-1:0]   out_word,
  output logic [n2ew_pkg::SEP_W-1:0]    out_separator,
  output logic                          out_last_word
);

  n2ew_pkg::conv_stat_t         conv_stat;
  n2ew_pkg::emit_cmd_t          emit_cmd;
  logic [n2ew_pkg::BCD_W-1:0]   digits;
  logic                         emit_busy;
  logic                         in_accept;
  logic                         in_err;

  assign in_stall  = conv_stat.busy || conv_stat.done || emit_busy;
  assign in_accept = in_valid && !in_stall;
  assign in_err    = (in_value > n2ew_pkg::VALUE_LIMIT);

  // Out-of-range values bypass the converter
  assign emit_cmd.start = (in_accept && in_err) || conv_stat.done;
  assign emit_cmd.err   = in_accept && in_err;

  n2ew_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept && !in_err),
    .value  (in_value),
    .digits (digits),
    .stat   (conv_stat)
  );

  n2ew_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (emit_cmd),
    .digits        (digits),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_separator (out_separator),
    .out_last_word (out_last_word)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for number_to_english_words: directed and random values, token checks.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_WORDS = 19;
  localparam int MAX_IDLE  = 11;

  // Scale words follow each other in code order: thousand, million, billion.
  localparam logic [n2ew_pkg::WORD_W-1:0] WORD_THOUSAND = 6'd29;

  typedef struct packed {
    logic [n2ew_pkg::WORD_W-1:0] word;
    logic [n2ew_pkg::SEP_W-1:0]  sep;
    logic                        last;
  } word_token_t;

  typedef struct {
    logic [n2ew_pkg::VALUE_W-1:0] value;
    bit                           drain;
    bit                           steady;
  } number_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [n2ew_pkg::VALUE_W-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [n2ew_pkg::WORD_W-1:0]  out_word;
  logic [n2ew_pkg::SEP_W-1:0]   out_separator;
  logic                         out_last_word;

  number_item_t numbers_pending[$];
  word_token_t  words_due[$];
  word_token_t  spelling[$];
  int           errors = 0;
  int           send_gap = 0;
  int           read_hold = 0;
  bit           steady = 1'b0;

  number_to_english_words DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_separator (out_separator),
    .out_last_word (out_last_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Append one word to the current spelling; drop anything past the token cap.
  function automatic void add_word(input logic [n2ew_pkg::WORD_W-1:0] w, input bit hyphen);
    word_token_t t;
    if (spelling.size() >= MAX_WORDS) return;
    t.word = w;
    if (spelling.size() == 0) t.sep = n2ew_pkg::SEP_NONE;
    else t.sep = hyphen ? n2ew_pkg::SEP_HYPHEN : n2ew_pkg::SEP_SPACE;
    t.last = 1'b0;
    spelling = {spelling, t};
  endfunction

  function automatic void add_group(input longint unsigned g);
    longint unsigned rest;
    longint unsigned hund;
    rest = g % 100;
    hund = g / 100;
    if (hund != 0) begin
      add_word(n2ew_pkg::WORD_W'(hund), 1'b0);
      add_word(n2ew_pkg::W_HUNDRED, 1'b0);
      if (rest == 0) return;
    end
    if (rest < 20) begin
      add_word(n2ew_pkg::WORD_W'(rest), 1'b0);
    end else begin
      add_word(n2ew_pkg::WORD_W'(n2ew_pkg::W_TENS_BASE + rest / 10), 1'b0);
      if (rest % 10 != 0) add_word(n2ew_pkg::WORD_W'(rest % 10), 1'b1);
    end
  endfunction

  function automatic void spell_number(input logic [n2ew_pkg::VALUE_W-1:0] v);
    longint unsigned n;
    longint unsigned grp [4];
    spelling.delete();
    n = v;
    if (v > n2ew_pkg::VALUE_LIMIT) begin
      add_word(n2ew_pkg::W_ERROR, 1'b0);
    end else if (n < 1000) begin
      add_group(n);
    end else begin
      for (int i = 0; i < 4; i++) begin
        grp[i] = n % 1000;
        n = n / 1000;
      end
      // Skip zero groups; every non-zero group above units takes its scale word.
      for (int i = 3; i >= 0; i--) begin
        if (grp[i] != 0) begin
          add_group(grp[i]);
          if (i > 0) add_word(n2ew_pkg::WORD_W'(WORD_THOUSAND + i - 1), 1'b0);
        end
      end
    end
    spelling[spelling.size() - 1].last = 1'b1;
    foreach (spelling[k]) words_due = {words_due, spelling[k]};
  endfunction

  // Driver: present queued numbers, hold while stalled, random idle gaps between transactions (none in steady runs).
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      send_gap = $urandom_range(0, MAX_IDLE);
    end else begin
      if (in_valid && !in_stall) begin
        spell_number(in_value);
        steady = numbers_pending[0].steady;
        void'(numbers_pending.pop_front());
        send_gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (numbers_pending.size() != 0 &&
                   (!numbers_pending[0].drain || words_due.size() == 0)) begin
        in_valid <= 1'b1;
        in_value <= numbers_pending[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random and compare every accepted token with the oldest prediction.
  always @(posedge clk) begin
    word_token_t exp_tok;
    if (!rst_n) begin
      out_stall <= 1'b0;
      read_hold = $urandom_range(0, MAX_IDLE);
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $error("unexpected token: word %0d separator %0d last_word %0d",
                 out_word, out_separator, out_last_word);
          errors++;
        end else begin
          exp_tok = words_due.pop_front();
          if (out_word !== exp_tok.word) begin
            $error("word: expected %0d, got %0d", exp_tok.word, out_word);
            errors++;
          end
          if (out_separator !== exp_tok.sep) begin
            $error("separator: expected %0d, got %0d", exp_tok.sep, out_separator);
            errors++;
          end
          if (out_last_word !== exp_tok.last) begin
            $error("last_word: expected %0d, got %0d", exp_tok.last, out_last_word);
            errors++;
          end
        end
        read_hold = steady ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (read_hold > 0) begin
        read_hold--;
      end
      out_stall <= (read_hold > 0);
    end
  end

  initial begin
    logic [n2ew_pkg::VALUE_W-1:0] directed [];
    number_item_t item;
    longint unsigned n;
    longint unsigned grp;

    directed = '{
      40'd0, 40'd1, 40'd9, 40'd10, 40'd11, 40'd19, 40'd20, 40'd21, 40'd99,
      40'd100, 40'd101, 40'd110, 40'd999, 40'd1000, 40'd1001, 40'd1000000,
      40'd1000000000, 40'd1000001000, 40'd100000000001, 40'd777777777777,
      40'd999999999999, 40'd1000000000000, 40'hFF_FFFF_FFFF, 40'h80_0000_0000
    };

    foreach (directed[k]) begin
      item.value  = directed[k];
      item.drain  = (k == 12);
      item.steady = 1'b0;
      numbers_pending = {numbers_pending, item};
    end

    for (int i = 0; i < 360; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          item.value[31:0]  = $urandom();
          item.value[39:32] = $urandom_range(0, 255);
        end
        1: begin
          // Build from three-digit groups, favouring zero groups, teens and round tens.
          n = 0;
          for (int g = 0; g < 4; g++) begin
            case ($urandom_range(0, 3))
              0: grp = 0;
              1: grp = $urandom_range(0, 999);
              2: grp = $urandom_range(0, 19);
              default: grp = $urandom_range(1, 9) * 100 + $urandom_range(2, 9) * 10;
            endcase
            n = n * 1000 + grp;
          end
          item.value = n2ew_pkg::VALUE_W'(n);
        end
        2: item.value = n2ew_pkg::VALUE_W'($urandom_range(0, 999));
        default: item.value = n2ew_pkg::VALUE_LIMIT - 3 +
                              n2ew_pkg::VALUE_W'($urandom_range(0, 6));
      endcase
      item.drain  = (i % 53 == 52);
      item.steady = ((i / 40) % 3 == 2);
      numbers_pending = {numbers_pending, item};
    end

    while (numbers_pending.size() != 0 || in_valid) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("number_to_english_words verification clean");
    end else begin
      $display("number_to_english_words verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("number_to_english_words verification failed");
    $finish;
  end

endmodule
